>>> rtl/oer_pkg.sv
package oer_pkg;

    // Q30 fixed-point one
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    // 2^32 / (2*pi), phase units per radian
    localparam logic [29:0] RAD_TO_PHASE = 30'd683565276;

    // pi/2 in Q30
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // Configuration register indexes
    localparam logic CFG_DEAD_ZONE = 1'b0;
    localparam logic CFG_ANGLE     = 1'b1;

    localparam logic [7:0]  DEAD_ZONE_RST = 8'd5;
    localparam logic [23:0] ANGLE_RST     = 24'd83886;

    // Quadrant codes, top two bits of the phase
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // Horner cells: divisor k*(k+1) for each series term
    localparam int SIN_CELLS = 6;
    localparam int COS_CELLS = 7;
    localparam int SIN_DIV [SIN_CELLS] = '{156, 110, 72, 42, 20, 6};
    localparam int COS_DIV [COS_CELLS] = '{182, 132, 90, 56, 30, 12, 2};

    // Taps of the side line that carries angle and quadrant past the cells
    localparam int SIDE_DEPTH = 14;
    localparam int SIDE_SIN_TAP = 2 * SIN_CELLS - 1;
    localparam int SIDE_COS_TAP = 2 * COS_CELLS - 1;

    typedef struct packed {
        logic [1:0]  quad;
        logic [30:0] x;
    } side_t;

    typedef struct packed {
        logic signed [31:0] look_x;
        logic signed [31:0] look_y;
        logic signed [31:0] look_z;
        logic signed [32:0] ex;
        logic signed [32:0] ey;
        logic signed [32:0] ez;
    } pay_t;

endpackage

>>> rtl/orbit_eye_rotator.sv
// Orbits an eye point about a look-at point by a mouse drag offset: dead
// zone on each offset, rotation about y by the x offset, then about z by the
// y offset, all in signed Q16.16 with saturated results. One word is taken
// per clock unless an output word is stalled. The depth is set by the
// sine/cosine unit, a chain of Horner cells of two stages each (seven for
// the cosine series), followed by two rotation stages of multiply then
// round. When an output word is stalled the whole pipeline holds and
// in_stall rises in the same cycle. Configuration writes are always ready
// and take effect at once.
module orbit_eye_rotator
    import oer_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [10:0] mouse_dx,
    input  logic signed [10:0] mouse_dy,
    input  logic signed [31:0] look_x,
    input  logic signed [31:0] look_y,
    input  logic signed [31:0] look_z,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] new_x,
    output logic signed [31:0] new_y,
    output logic signed [31:0] new_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [23:0]        cfg_data
);

    localparam int NSTAGE    = 25;
    localparam int PAY_DEPTH = 19;
    localparam int TRIG_OUT  = 19;

    localparam logic signed [65:0] HALF_LSB_66 = 66'sd536870912;
    localparam logic signed [67:0] HALF_LSB_68 = 68'sd536870912;

    function automatic logic signed [10:0] dead_fn(input logic signed [10:0] v,
                                                  input logic [7:0] dz);
        logic signed [11:0] t;
        if (v < 0)
        begin
            t = $signed({v[10], v}) + $signed({4'b0000, dz});
            if (t > 0)
                t = '0;
        end
        else
        begin
            t = $signed({v[10], v}) - $signed({4'b0000, dz});
            if (t < 0)
                t = '0;
        end
        return t[10:0];
    endfunction

    function automatic logic signed [31:0] sat_fn(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -37'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    logic [7:0]  dead_zone_reg;
    logic [23:0] angle_reg;

    logic               en;
    logic [NSTAGE-1:0]  vld_reg;

    logic signed [10:0] dx_reg;
    logic signed [10:0] dy_reg;
    pay_t               s1_reg;
    pay_t               pay_reg [PAY_DEPTH];

    logic signed [31:0] sh_w, ch_w, sv_w, cv_w;

    // first rotation
    logic signed [64:0] rxa_reg, rxb_reg, rza_reg, rzb_reg;
    logic signed [31:0] r1_sv_reg, r1_cv_reg;
    pay_t               r1_pay_reg;
    logic signed [34:0] x1_reg, z1_reg;
    logic signed [31:0] r2_sv_reg, r2_cv_reg;
    pay_t               r2_pay_reg;
    // second rotation
    logic signed [66:0] rxc_reg, rxd_reg, ryc_reg, ryd_reg;
    logic signed [34:0] r3_z1_reg;
    pay_t               r3_pay_reg;
    logic signed [35:0] x2_reg, y2_reg;
    logic signed [34:0] r4_z1_reg;
    pay_t               r4_pay_reg;

    logic signed [31:0] new_x_reg, new_y_reg, new_z_reg;

    logic signed [64:0] rxa_next, rxb_next, rza_next, rzb_next;
    logic signed [65:0] x1_sum, z1_sum;
    logic signed [66:0] rxc_next, rxd_next, ryc_next, ryd_next;
    logic signed [67:0] x2_sum, y2_sum;
    logic signed [36:0] fx_sum, fy_sum, fz_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= DEAD_ZONE_RST;
            angle_reg     <= ANGLE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEAD_ZONE: dead_zone_reg <= cfg_data[7:0];
                CFG_ANGLE:     angle_reg     <= cfg_data;
                default:       angle_reg     <= angle_reg;
            endcase
        end
    end

    // hold every stage while the output word waits
    assign en       = !(vld_reg[NSTAGE-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
    end

    oer_trig u_trig_h (
        .clk     (clk),
        .en      (en),
        .counts  (dx_reg),
        .angle   (angle_reg),
        .sin_val (sh_w),
        .cos_val (ch_w)
    );

    oer_trig u_trig_v (
        .clk     (clk),
        .en      (en),
        .counts  (dy_reg),
        .angle   (angle_reg),
        .sin_val (sv_w),
        .cos_val (cv_w)
    );

    always_comb
    begin
        rxa_next = ch_w * pay_reg[PAY_DEPTH-1].ex;
        rxb_next = sh_w * pay_reg[PAY_DEPTH-1].ez;
        rza_next = sh_w * pay_reg[PAY_DEPTH-1].ex;
        rzb_next = ch_w * pay_reg[PAY_DEPTH-1].ez;
        x1_sum   = 66'(rxa_reg) - 66'(rxb_reg) + HALF_LSB_66;
        z1_sum   = 66'(rza_reg) + 66'(rzb_reg) + HALF_LSB_66;
        rxc_next = r2_cv_reg * x1_reg;
        rxd_next = r2_sv_reg * r2_pay_reg.ey;
        ryc_next = r2_sv_reg * x1_reg;
        ryd_next = r2_cv_reg * r2_pay_reg.ey;
        x2_sum   = 68'(rxc_reg) - 68'(rxd_reg) + HALF_LSB_68;
        y2_sum   = 68'(ryc_reg) + 68'(ryd_reg) + HALF_LSB_68;
        fx_sum   = 37'(x2_reg) + 37'(r4_pay_reg.look_x);
        fy_sum   = 37'(y2_reg) + 37'(r4_pay_reg.look_y);
        fz_sum   = 37'(r4_z1_reg) + 37'(r4_pay_reg.look_z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg        <= dead_fn(mouse_dx, dead_zone_reg);
            dy_reg        <= dead_fn(mouse_dy, dead_zone_reg);
            s1_reg.look_x <= look_x;
            s1_reg.look_y <= look_y;
            s1_reg.look_z <= look_z;
            s1_reg.ex     <= 33'(eye_x) - 33'(look_x);
            s1_reg.ey     <= 33'(eye_y) - 33'(look_y);
            s1_reg.ez     <= 33'(eye_z) - 33'(look_z);

            pay_reg[0] <= s1_reg;
            for (int k = 1; k < PAY_DEPTH; k++)
            begin
                pay_reg[k] <= pay_reg[k - 1];
            end

            rxa_reg    <= rxa_next;
            rxb_reg    <= rxb_next;
            rza_reg    <= rza_next;
            rzb_reg    <= rzb_next;
            r1_sv_reg  <= sv_w;
            r1_cv_reg  <= cv_w;
            r1_pay_reg <= pay_reg[PAY_DEPTH-1];

            x1_reg     <= x1_sum[64:30];
            z1_reg     <= z1_sum[64:30];
            r2_sv_reg  <= r1_sv_reg;
            r2_cv_reg  <= r1_cv_reg;
            r2_pay_reg <= r1_pay_reg;

            rxc_reg    <= rxc_next;
            rxd_reg    <= rxd_next;
            ryc_reg    <= ryc_next;
            ryd_reg    <= ryd_next;
            r3_z1_reg  <= z1_reg;
            r3_pay_reg <= r2_pay_reg;

            x2_reg     <= x2_sum[65:30];
            y2_reg     <= y2_sum[65:30];
            r4_z1_reg  <= r3_z1_reg;
            r4_pay_reg <= r3_pay_reg;

            new_x_reg  <= sat_fn(fx_sum);
            new_y_reg  <= sat_fn(fy_sum);
            new_z_reg  <= sat_fn(fz_sum);
        end
    end

    assign out_valid = vld_reg[NSTAGE-1];
    assign new_x     = new_x_reg;
    assign new_y     = new_y_reg;
    assign new_z     = new_z_reg;

`ifndef SYNTHESIS
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(vld_reg))
        else $error("pipeline advanced while output word was stalled");

    a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |=> (vld_reg[0] == $past(in_valid)))
        else $error("first stage valid does not follow accepted input");

    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[TRIG_OUT] |-> (sh_w <= 32'sd1073742848 && sh_w >= -32'sd1073742848
            && cv_w <= 32'sd1073742848 && cv_w >= -32'sd1073742848))
        else $error("sine or cosine out of unit range");
`endif

endmodule

>>> rtl/oer_horner_cell.sv
module oer_horner_cell
    import oer_pkg::*;
#(
    parameter int DIV = 6
)
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        x2_in,
    input  logic signed [31:0] t_in,
    output logic [31:0]        x2_out,
    output logic signed [31:0] t_out
);

    localparam int DIV_BITS = $clog2(DIV);
    localparam int SHIFT    = 32 + DIV_BITS;
    // floor(p / DIV) = floor(p * RECIP / 2^SHIFT) for every 32-bit p
    localparam logic [33:0] RECIP = 34'(((64'd1 << SHIFT) / DIV) + 1);

    logic [31:0]        p_reg;
    logic [31:0]        x2_a_reg;
    logic [31:0]        x2_b_reg;
    logic signed [31:0] t_reg;

    logic [62:0] prod_a;
    logic [65:0] prod_b;
    logic [65:0] quot_full;
    logic signed [33:0] t_next;

    always_comb
    begin
        prod_a    = x2_in * t_in[30:0];
        prod_b    = p_reg * RECIP;
        quot_full = prod_b >> SHIFT;
        t_next    = 34'(ONE_Q30) - $signed({2'b00, quot_full[31:0]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= prod_a[61:30];
            x2_a_reg <= x2_in;
            t_reg    <= t_next[31:0];
            x2_b_reg <= x2_a_reg;
        end
    end

    assign x2_out = x2_b_reg;
    assign t_out  = t_reg;

endmodule

>>> rtl/oer_trig.sv
module oer_trig
    import oer_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [10:0] counts,
    input  logic [23:0]        angle,
    output logic signed [31:0] sin_val,
    output logic signed [31:0] cos_val
);

    logic signed [35:0] a_reg;
    logic [31:0]        ph_reg;
    logic [30:0]        x_reg;
    logic [1:0]         q_reg;
    logic [30:0]        x_t4_reg;
    logic [1:0]         q_t4_reg;
    logic [31:0]        x2_reg;
    side_t              side_reg [SIDE_DEPTH];
    logic signed [31:0] sn_reg;
    logic signed [31:0] sn_d_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] c_reg;

    logic signed [35:0] a_next;
    logic signed [66:0] ph_prod;
    logic [60:0]        x_prod;
    logic [61:0]        sq_prod;
    logic [61:0]        sn_prod;
    logic signed [31:0] s_next;
    logic signed [31:0] c_next;

    logic [31:0]        sin_x2 [SIN_CELLS + 1];
    logic signed [31:0] sin_t  [SIN_CELLS + 1];
    logic [31:0]        cos_x2 [COS_CELLS + 1];
    logic signed [31:0] cos_t  [COS_CELLS + 1];

    assign sin_x2[0] = x2_reg;
    assign sin_t[0]  = ONE_Q30;
    assign cos_x2[0] = x2_reg;
    assign cos_t[0]  = ONE_Q30;

    genvar i;
    generate
        for (i = 0; i < SIN_CELLS; i++)
        begin : g_sin
            oer_horner_cell #(.DIV(SIN_DIV[i])) u_cell (
                .clk    (clk),
                .en     (en),
                .x2_in  (sin_x2[i]),
                .t_in   (sin_t[i]),
                .x2_out (sin_x2[i + 1]),
                .t_out  (sin_t[i + 1])
            );
        end
        for (i = 0; i < COS_CELLS; i++)
        begin : g_cos
            oer_horner_cell #(.DIV(COS_DIV[i])) u_cell (
                .clk    (clk),
                .en     (en),
                .x2_in  (cos_x2[i]),
                .t_in   (cos_t[i]),
                .x2_out (cos_x2[i + 1]),
                .t_out  (cos_t[i + 1])
            );
        end
    endgenerate

    always_comb
    begin
        a_next  = counts * $signed({1'b0, angle});
        ph_prod = a_reg * $signed({1'b0, RAD_TO_PHASE});
        x_prod  = ph_reg[29:0] * HALF_PI_Q30;
        sq_prod = x_reg * x_reg;
        sn_prod = side_reg[SIDE_SIN_TAP].x * sin_t[SIN_CELLS][30:0];
    end

    // fold the first-quadrant pair into the quadrant of the phase
    always_comb
    begin
        case (side_reg[SIDE_COS_TAP].quad)
            QUAD_0:
            begin
                s_next = sn_d_reg;
                c_next = cos_t[COS_CELLS];
            end
            QUAD_1:
            begin
                s_next = cos_t[COS_CELLS];
                c_next = -sn_d_reg;
            end
            QUAD_2:
            begin
                s_next = -sn_d_reg;
                c_next = -cos_t[COS_CELLS];
            end
            default:
            begin
                s_next = -cos_t[COS_CELLS];
                c_next = sn_d_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            ph_reg   <= ph_prod[55:24];
            x_reg    <= x_prod[60:30];
            q_reg    <= ph_reg[31:30];
            x_t4_reg <= x_reg;
            q_t4_reg <= q_reg;
            x2_reg   <= sq_prod[61:30];
            side_reg[0] <= '{quad: q_t4_reg, x: x_t4_reg};
            for (int k = 1; k < SIDE_DEPTH; k++)
            begin
                side_reg[k] <= side_reg[k - 1];
            end
            sn_reg   <= $signed(sn_prod[61:30]);
            sn_d_reg <= sn_reg;
            s_reg    <= s_next;
            c_reg    <= c_next;
        end
    end

    assign sin_val = s_reg;
    assign cos_val = c_reg;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import oer_pkg::*;

    typedef struct {
        logic signed [10:0] dx;
        logic signed [10:0] dy;
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [31:0] lz;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
    } drag_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } eye_t;

    localparam longint PHASE_PER_RAD = 64'd683565276;
    localparam longint QUARTER_TURN  = 64'd1686629713;
    localparam longint UNIT_Q30      = 64'sd1073741824;
    localparam int     PIPE_DEPTH    = 25;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [10:0] mouse_dx;
    logic signed [10:0] mouse_dy;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [23:0] cfg_data;

    // model copy of the configuration
    logic [7:0]  dead_zone_val;
    logic [23:0] angle_step_val;

    eye_t expected_eyes[$];
    int errors;
    int words_sent;
    int words_checked;
    bit idle_en;
    bit hold_off;

    orbit_eye_rotator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mouse_dx(mouse_dx), .mouse_dy(mouse_dy),
        .look_x(look_x), .look_y(look_y), .look_z(look_z),
        .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .new_x(new_x), .new_y(new_y), .new_z(new_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint apply_dead_zone(input longint v);
        longint dz;
        dz = longint'(dead_zone_val);
        if (v < 0)
        begin
            v += dz;
            if (v > 0) v = 0;
        end
        else
        begin
            v -= dz;
            if (v < 0) v = 0;
        end
        return v;
    endfunction

    function automatic void sin_cos(input longint counts, output longint s, output longint c);
        longint unsigned ang;
        longint unsigned prod;
        logic [31:0] phase;
        longint r;
        longint x;
        longint x2;
        longint ts;
        longint tc;
        longint sn;
        longint cs;
        longint k;
        ang = counts * longint'(angle_step_val);
        prod = ang * PHASE_PER_RAD;
        phase = prod[55:24];
        r = longint'(phase[29:0]);
        x = (r * QUARTER_TURN) >>> 30;
        x2 = (x * x) >>> 30;
        ts = UNIT_Q30;
        tc = UNIT_Q30;
        for (k = 12; k >= 2; k -= 2)
            ts = UNIT_Q30 - ((x2 * ts) >>> 30) / (k * (k + 1));
        sn = (x * ts) >>> 30;
        for (k = 13; k >= 3; k -= 2)
            tc = UNIT_Q30 - ((x2 * tc) >>> 30) / (k * (k + 1));
        cs = UNIT_Q30 - ((x2 * tc) >>> 30) / 2;
        case (phase[31:30])
            QUAD_0:  begin s = sn;  c = cs;  end
            QUAD_1:  begin s = cs;  c = -sn; end
            QUAD_2:  begin s = -sn; c = -cs; end
            default: begin s = -cs; c = sn;  end
        endcase
    endfunction

    function automatic longint round_from_q30(input longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic eye_t orbit_eye(input drag_t d);
        eye_t res;
        longint ex;
        longint ey;
        longint ez;
        longint sh;
        longint ch;
        longint sv;
        longint cv;
        longint x1;
        longint z1;
        longint x2;
        longint y2;
        ex = longint'(d.ex) - longint'(d.lx);
        ey = longint'(d.ey) - longint'(d.ly);
        ez = longint'(d.ez) - longint'(d.lz);
        sin_cos(apply_dead_zone(longint'(d.dx)), sh, ch);
        x1 = round_from_q30(ch * ex - sh * ez);
        z1 = round_from_q30(sh * ex + ch * ez);
        sin_cos(apply_dead_zone(longint'(d.dy)), sv, cv);
        x2 = round_from_q30(cv * x1 - sv * ey);
        y2 = round_from_q30(sv * x1 + cv * ey);
        res.x = clamp32(x2 + longint'(d.lx));
        res.y = clamp32(y2 + longint'(d.ly));
        res.z = clamp32(z1 + longint'(d.lz));
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: %s mismatch at %0t: got %h expected %h", what, $realtime, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        eye_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_eyes.size() == 0)
            begin
                $display("tb: unexpected word at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = expected_eyes.pop_front();
                if (new_x !== want.x) report_mismatch("new_x", new_x, want.x);
                if (new_y !== want.y) report_mismatch("new_y", new_y, want.y);
                if (new_z !== want.z) report_mismatch("new_z", new_z, want.z);
                words_checked++;
            end
        end
    end

    // output stall: random, or held for a long stretch
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= idle_en && ($urandom_range(99) < 32);
    end

    task automatic send_word(input drag_t d);
        while (idle_en && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mouse_dx <= d.dx;
        mouse_dy <= d.dy;
        look_x <= d.lx;
        look_y <= d.ly;
        look_z <= d.lz;
        eye_x <= d.ex;
        eye_y <= d.ey;
        eye_z <= d.ez;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_eyes.push_back(orbit_eye(d));
        words_sent++;
    endtask

    task automatic drain();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (expected_eyes.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (PIPE_DEPTH + 5) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [23:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_DEAD_ZONE)
            dead_zone_val = val[7:0];
        else
            angle_step_val = val;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(4000000)) - 32'sd2000000;
            2: return $signed($urandom_range(200)) - 32'sd100;
            default: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3) :
                                                 32'sh80000000 + $urandom_range(3);
        endcase
    endfunction

    function automatic logic signed [10:0] rand_offset();
        if ($urandom_range(3) == 0)
            return 11'($urandom);
        return $signed(11'($urandom_range(160))) - 11'sd80;
    endfunction

    function automatic drag_t rand_drag();
        drag_t d;
        d.dx = rand_offset();
        d.dy = rand_offset();
        d.lx = rand_coord();
        d.ly = rand_coord();
        d.lz = rand_coord();
        d.ex = rand_coord();
        d.ey = rand_coord();
        d.ez = rand_coord();
        return d;
    endfunction

    function automatic drag_t make_drag(input int dx, input int dy, input int lc, input int ec);
        drag_t d;
        d.dx = 11'(dx);
        d.dy = 11'(dy);
        d.lx = lc;
        d.ly = lc;
        d.lz = lc;
        d.ex = ec;
        d.ey = ec;
        d.ez = ec;
        return d;
    endfunction

    task automatic test_directed();
        int offs[8] = '{-1024, 1023, 0, 5, -5, 6, -6, 400};
        drag_t d;
        for (int i = 0; i < 8; i++)
            send_word(make_drag(offs[i], offs[7 - i], 32'sh00010000, 32'sh00050000));
        // overflow on the final sums both ways
        send_word(make_drag(300, 0, 32'sh7fffffff, 32'sh80000000));
        send_word(make_drag(-300, 300, 32'sh80000000, 32'sh7fffffff));
        send_word(make_drag(-1024, -1024, 32'sh80000000, 32'sh80000000));
        send_word(make_drag(1023, 1023, 32'sh7fffffff, 32'sh7fffffff));
        d = make_drag(200, -200, 0, 0);
        d.ex = 32'sh7fffffff;
        d.ez = 32'sh80000000;
        send_word(d);
    endtask

    task automatic test_config_sweep();
        write_reg(CFG_DEAD_ZONE, 24'd0);
        write_reg(CFG_ANGLE, 24'hffffff);
        test_directed();
        repeat (150) send_word(rand_drag());
        write_reg(CFG_DEAD_ZONE, 24'd255);
        write_reg(CFG_ANGLE, 24'd0);
        test_directed();
        repeat (100) send_word(rand_drag());
        // large angles wrap through the phase
        write_reg(CFG_DEAD_ZONE, 24'd1);
        write_reg(CFG_ANGLE, 24'd1234567);
        repeat (150) send_word(rand_drag());
        write_reg(CFG_DEAD_ZONE, 24'd5);
        write_reg(CFG_ANGLE, 24'd83886);
    endtask

    task automatic test_random();
        repeat (600) send_word(rand_drag());
        // back to back, no gaps on either side
        drain();
        idle_en = 1'b0;
        repeat (300) send_word(rand_drag());
        idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        drain();
        hold_off <= 1'b1;
        fork
            begin
                repeat (150) @(posedge clk);
                hold_off <= 1'b0;
            end
            repeat (150) send_word(rand_drag());
        join
    endtask

    initial
    begin
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        idle_en = 1'b1;
        hold_off = 1'b0;
        dead_zone_val = DEAD_ZONE_RST;
        angle_step_val = ANGLE_RST;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        mouse_dx = '0;
        mouse_dy = '0;
        look_x = '0;
        look_y = '0;
        look_z = '0;
        eye_x = '0;
        eye_y = '0;
        eye_z = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DEAD_ZONE;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_sweep();
        test_random();
        test_backpressure();
        drain();

        $display("tb: %0d words sent, %0d results checked", words_sent, words_checked);
        $display("tb: covered dead zone and angle extremes, wrap, saturation, long stall");
        if (errors == 0 && expected_eyes.size() == 0)
            $display("tb: success");
        else
        begin
            if (expected_eyes.size() != 0)
                $display("tb: %0d results never arrived", expected_eyes.size());
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: timeout");
        $display("tb: failure");
        $finish;
    end

endmodule
